// ----- rtl/dtq_pkg.sv -----
// types and constants shared by the deadline timer queue
package dtq_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = 4;
    localparam int MAX_RES = 16;
    localparam int CNT_W   = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;

    localparam logic [2:0] KIND_INSERTED  = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_EXPIRED   = 3'd4;
    localparam logic [2:0] KIND_NONE      = 3'd5;

    localparam logic [62:0] TIME_MAX = {63{1'b1}};

    typedef struct packed {
        logic [1:0]  mode;
        logic [62:0] time_value;
        logic [47:0] interval_us;
        logic [3:0]  cancel_slot;
        logic [15:0] cancel_tag;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot_out;
        logic [15:0] tag_out;
        logic        rearmed;
        logic        became_earliest;
        logic [62:0] next_deadline;
        logic        deadline_valid;
        logic        last;
    } t_result;

    // per-result fields known before the closing earliest-deadline scan
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot_out;
        logic [15:0] tag_out;
        logic        rearmed;
        logic        became_earliest;
    } t_res;

    typedef struct packed {
        logic [62:0] deadline;
        logic [47:0] interval;
        logic [15:0] tag;
        logic [31:0] order;
    } t_entry;

endpackage

// ----- rtl/dtq_ram.sv -----
// generic single-write, single-read ram with registered read data
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/deadline_timer_queue_unit.sv -----
// deadline timer queue: timer table in a ram, scanned by a sequencer
// sequence: a cancel first reads its slot and a tick first runs s pick scans (k+1 for k<16
// expired timers, 16 when 16 expire); then the earliest scan, then one result per cycle
// throughput: one item at a time, busy stays high until the cycle that shows the last result
// the receiver cannot stall results
// reset: synchronous active low, clears all active flags and both counters
module deadline_timer_queue_unit
    import dtq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_result_strobe,
    output t_result o_result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;  // pick the next expired timer
    localparam logic [2:0] ST_MIN  = 3'd2;  // earliest active deadline
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_CRD  = 3'd4;
    localparam logic [2:0] ST_CCK  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0]        r_state;
    t_cmd              r_cmd;
    logic [SLOTS-1:0]  r_active;
    logic [SLOTS-1:0]  r_done;      // already emitted in this tick
    logic [15:0]       r_tag_cnt;
    logic [31:0]       r_ord_cnt;
    logic              r_full;
    logic [SLOT_W-1:0] r_free;

    // scan pipeline: read address counter and data-valid stage
    logic [CNT_W-1:0]  r_ra;
    logic              r_dv;
    logic [SLOT_W-1:0] r_di;

    // best candidate of the current pick scan
    logic              r_have;
    t_entry            r_best;
    logic [SLOT_W-1:0] r_best_idx;
    logic [31:0]       r_best_age;

    // earliest deadline scan
    logic              r_min_any;
    logic [62:0]       r_min_dl;

    // result buffer
    t_res              r_buf [MAX_RES];
    logic [CNT_W-1:0]  r_n;
    logic [SLOT_W-1:0] r_eidx;
    logic [62:0]       r_next;
    logic              r_next_ok;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    t_entry            ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    t_entry            ram_rdata;

    logic              accept;
    logic              scan_issue;
    logic              scan_end;
    logic [31:0]       rd_age;
    logic              rd_due;
    logic              rd_better;
    logic [63:0]       rearm_sum;
    logic [62:0]       rearm_dl;
    logic              periodic;
    logic              early;
    logic              cancel_hit;
    logic [SLOT_W-1:0] free_idx;
    logic              any_free;

    assign accept     = i_start && !o_busy;
    assign o_busy     = (r_state != ST_IDLE);
    assign scan_issue = (r_state == ST_SCAN || r_state == ST_MIN) && !r_ra[CNT_W-1];
    assign scan_end   = r_ra[CNT_W-1] && !r_dv;

    assign rd_age    = r_ord_cnt - ram_rdata.order;
    assign rd_due    = r_active[r_di] && !r_done[r_di] && (ram_rdata.deadline <= r_cmd.time_value);
    assign rd_better = !r_have || (ram_rdata.deadline < r_best.deadline) ||
                       ((ram_rdata.deadline == r_best.deadline) && (rd_age > r_best_age));

    assign periodic  = (r_best.interval != 48'd0);
    assign rearm_sum = {1'b0, r_cmd.time_value} + {16'd0, r_best.interval};
    assign rearm_dl  = rearm_sum[63] ? TIME_MAX : rearm_sum[62:0];

    assign early      = !r_min_any || (r_cmd.time_value < r_min_dl);
    assign cancel_hit = r_active[r_cmd.cancel_slot] && (ram_rdata.tag == r_cmd.cancel_tag);

    // lowest free slot
    always_comb begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!i_rst_n || !r_active[i]) begin
                free_idx = SLOT_W'(i);
                any_free = 1'b1;
            end
        end
    end

    // ram port control
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_ra[SLOT_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_best_idx;
        ram_wdata = '{deadline: rearm_dl, interval: r_best.interval,
                      tag: r_best.tag, order: r_ord_cnt};
        if (scan_issue) begin
            ram_re = 1'b1;
        end else if (r_state == ST_CRD) begin
            ram_re    = 1'b1;
            ram_raddr = r_cmd.cancel_slot;
        end
        if (r_state == ST_SCAN && scan_end && r_have && periodic) begin
            ram_we = 1'b1;
        end else if (r_state == ST_FIN && r_cmd.mode == MODE_INSERT && !r_full) begin
            ram_we    = 1'b1;
            ram_waddr = r_free;
            ram_wdata = '{deadline: r_cmd.time_value, interval: r_cmd.interval_us,
                          tag: r_tag_cnt + 16'd1, order: r_ord_cnt};
        end
    end

    dtq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // scan pipeline, shared by the pick and earliest scans
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra <= '0;
            r_dv <= 1'b0;
        end else begin
            r_dv <= scan_issue;
            r_di <= r_ra[SLOT_W-1:0];
            if (scan_issue) begin
                r_ra <= r_ra + CNT_W'(1);
            end else if (scan_end || accept) begin
                r_ra <= '0;  // rescan or start the next scan
            end
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_active        <= '0;
            r_tag_cnt       <= '0;
            r_ord_cnt       <= '0;
            r_have          <= 1'b0;
            r_min_any       <= 1'b0;
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd     <= i_cmd;
                        r_done    <= '0;
                        r_n       <= '0;
                        r_have    <= 1'b0;
                        r_min_any <= 1'b0;
                        r_min_dl  <= '0;
                        r_full    <= !any_free;
                        r_free    <= free_idx;
                        if (i_cmd.mode == MODE_INSERT) begin
                            r_state <= ST_MIN;
                        end else if (i_cmd.mode == MODE_CANCEL) begin
                            r_state <= ST_CRD;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_dv && rd_due && rd_better) begin
                        r_have     <= 1'b1;
                        r_best     <= ram_rdata;
                        r_best_idx <= r_di;
                        r_best_age <= rd_age;
                    end
                    if (scan_end) begin
                        r_have <= 1'b0;
                        if (r_have) begin
                            r_buf[r_n[SLOT_W-1:0]] <= '{kind: KIND_EXPIRED,
                                slot_out: r_best_idx, tag_out: r_best.tag,
                                rearmed: periodic, became_earliest: 1'b0};
                            r_done[r_best_idx] <= 1'b1;
                            if (periodic) begin
                                r_ord_cnt <= r_ord_cnt + 32'd1;
                            end else begin
                                r_active[r_best_idx] <= 1'b0;
                            end
                            r_n <= r_n + CNT_W'(1);
                            if (r_n == CNT_W'(MAX_RES - 1)) begin
                                r_state <= ST_MIN;
                            end
                        end else begin
                            if (r_n == '0) begin
                                r_buf[0] <= '{kind: KIND_NONE, slot_out: '0, tag_out: '0,
                                              rearmed: 1'b0, became_earliest: 1'b0};
                                r_n      <= CNT_W'(1);
                            end
                            r_state <= ST_MIN;
                        end
                    end
                end
                ST_CRD: begin
                    r_state <= ST_CCK;
                end
                ST_CCK: begin
                    if (cancel_hit) begin
                        r_active[r_cmd.cancel_slot] <= 1'b0;
                    end
                    r_buf[0] <= '{kind: cancel_hit ? KIND_CANCELLED : KIND_NOT_FOUND,
                                  slot_out: r_cmd.cancel_slot, tag_out: r_cmd.cancel_tag,
                                  rearmed: 1'b0, became_earliest: 1'b0};
                    r_n      <= CNT_W'(1);
                    r_state  <= ST_MIN;
                end
                ST_MIN: begin
                    if (r_dv && r_active[r_di] &&
                        (!r_min_any || ram_rdata.deadline < r_min_dl)) begin
                        r_min_any <= 1'b1;
                        r_min_dl  <= ram_rdata.deadline;
                    end
                    if (scan_end) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_next    <= r_min_dl;
                    r_next_ok <= r_min_any;
                    if (r_cmd.mode == MODE_INSERT) begin
                        r_n <= CNT_W'(1);
                        if (r_full) begin
                            r_buf[0] <= '{kind: KIND_FULL, slot_out: '0, tag_out: '0,
                                          rearmed: 1'b0, became_earliest: 1'b0};
                        end else begin
                            r_buf[0] <= '{kind: KIND_INSERTED, slot_out: r_free,
                                          tag_out: r_tag_cnt + 16'd1,
                                          rearmed: 1'b0, became_earliest: early};
                            r_active[r_free] <= 1'b1;
                            r_tag_cnt        <= r_tag_cnt + 16'd1;
                            r_ord_cnt        <= r_ord_cnt + 32'd1;
                            r_next_ok        <= 1'b1;
                            if (early) begin
                                r_next <= r_cmd.time_value;
                            end
                        end
                    end
                    r_eidx  <= '0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    o_result_strobe <= 1'b1;
                    o_result        <= '{kind: r_buf[r_eidx].kind,
                        slot_out: r_buf[r_eidx].slot_out, tag_out: r_buf[r_eidx].tag_out,
                        rearmed: r_buf[r_eidx].rearmed,
                        became_earliest: r_buf[r_eidx].became_earliest,
                        next_deadline: r_next_ok ? r_next : 63'd0,
                        deadline_valid: r_next_ok,
                        last: ({1'b0, r_eidx} == r_n - CNT_W'(1))};
                    r_eidx <= r_eidx + SLOT_W'(1);
                    if ({1'b0, r_eidx} == r_n - CNT_W'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- verif/tb_deadline_timer_queue_unit.sv -----
// testbench for the deadline timer queue: directed and random commands checked against a predictor
module tb_deadline_timer_queue_unit
    import dtq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // tick mode has no package constant; mode 3 also acts as a tick
    localparam logic [1:0] MODE_TICK  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         CYCLE_LIMIT = 1500000;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    t_cmd    i_cmd;
    logic    o_busy;
    logic    o_result_strobe;
    t_result o_result;

    deadline_timer_queue_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_cmd           (i_cmd),
        .o_busy          (o_busy),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    // predictor copy of the timer table
    logic        tmr_active   [SLOTS];
    logic [62:0] tmr_deadline [SLOTS];
    logic [47:0] tmr_interval [SLOTS];
    logic [15:0] tmr_tag      [SLOTS];
    logic [31:0] tmr_order    [SLOTS];
    logic [15:0] tag_count;
    logic [31:0] order_count;

    t_result expected_results[$];
    int      mismatch_count;
    int      unexpected_count;
    int      cycle_count;
    logic    no_idle;       // long stretch without sender gaps
    logic [15:0] last_tag;  // most recent tag handed out, for cancels aimed at idle slots

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // earliest active deadline, 0 and invalid when the table is empty
    function automatic void find_earliest(output logic [62:0] dl, output logic valid);
        dl = '0;
        valid = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (tmr_active[i] && (!valid || tmr_deadline[i] < dl)) begin
                dl = tmr_deadline[i];
                valid = 1'b1;
            end
        end
    endfunction

    // apply one command to the table and queue the results it must cause
    task automatic predict_command(input t_cmd cmd);
        t_result     res[$];
        t_result     r;
        logic        due [SLOTS];
        logic [62:0] cur;
        logic        any;
        logic [63:0] sum;
        int          free_slot;
        int          pick;
        begin
            r = '0;
            if (cmd.mode == MODE_INSERT) begin
                free_slot = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!tmr_active[i]) free_slot = i;
                if (free_slot < 0) begin
                    r.kind = KIND_FULL;
                end else begin
                    find_earliest(cur, any);
                    tag_count++;
                    tmr_active[free_slot]   = 1'b1;
                    tmr_deadline[free_slot] = cmd.time_value;
                    tmr_interval[free_slot] = cmd.interval_us;
                    tmr_tag[free_slot]      = tag_count;
                    tmr_order[free_slot]    = order_count++;
                    r.kind            = KIND_INSERTED;
                    r.slot_out        = free_slot[3:0];
                    r.tag_out         = tag_count;
                    r.became_earliest = !any || cmd.time_value < cur;
                    last_tag          = tag_count;
                end
                res.push_back(r);
            end else if (cmd.mode == MODE_CANCEL) begin
                r.slot_out = cmd.cancel_slot;
                r.tag_out  = cmd.cancel_tag;
                if (tmr_active[cmd.cancel_slot] && tmr_tag[cmd.cancel_slot] == cmd.cancel_tag)
                begin
                    tmr_active[cmd.cancel_slot] = 1'b0;
                    r.kind = KIND_CANCELLED;
                end else begin
                    r.kind = KIND_NOT_FOUND;
                end
                res.push_back(r);
            end else begin
                // tick: only timers due at the start of the tick may fire
                for (int i = 0; i < SLOTS; i++)
                    due[i] = tmr_active[i] && tmr_deadline[i] <= cmd.time_value;
                while (res.size() < MAX_RES) begin
                    pick = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!due[i]) continue;
                        // ties go to the oldest order stamp, measured modulo the counter
                        if (pick < 0 || tmr_deadline[i] < tmr_deadline[pick] ||
                            (tmr_deadline[i] == tmr_deadline[pick] &&
                             (order_count - tmr_order[i]) > (order_count - tmr_order[pick])))
                            pick = i;
                    end
                    if (pick < 0) break;
                    due[pick] = 1'b0;
                    r = '0;
                    r.kind     = KIND_EXPIRED;
                    r.slot_out = pick[3:0];
                    r.tag_out  = tmr_tag[pick];
                    if (tmr_interval[pick] != 0) begin
                        // re-arm saturates at the top of the time range
                        sum = {1'b0, cmd.time_value} + {16'd0, tmr_interval[pick]};
                        tmr_deadline[pick] = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[62:0];
                        tmr_order[pick] = order_count++;
                        r.rearmed = 1'b1;
                    end else begin
                        tmr_active[pick] = 1'b0;
                    end
                    res.push_back(r);
                end
                if (res.size() == 0) begin
                    r = '0;
                    r.kind = KIND_NONE;
                    res.push_back(r);
                end
            end
            find_earliest(cur, any);
            foreach (res[k]) begin
                res[k].next_deadline  = cur;
                res[k].deadline_valid = any;
                res[k].last           = (k == res.size() - 1);
                expected_results.push_back(res[k]);
            end
        end
    endtask

    // one transfer: wait for the block to be free, present the command, wait for acceptance
    task automatic send_command(input t_cmd cmd);
        begin
            while (!no_idle && $urandom_range(99) < 19) @(posedge i_clk);
            while (o_busy) @(posedge i_clk);
            i_start <= 1'b1;
            i_cmd   <= cmd;
            @(posedge i_clk);
            while (o_busy) @(posedge i_clk);
            predict_command(cmd);
            i_start <= 1'b0;
            // let busy rise before the next look at it
            @(posedge i_clk);
        end
    endtask

    function automatic t_cmd make_cmd(input logic [1:0] mode, input logic [62:0] tv,
                                      input logic [47:0] iv, input logic [3:0] cs,
                                      input logic [15:0] ct);
        t_cmd c;
        c.mode = mode; c.time_value = tv; c.interval_us = iv;
        c.cancel_slot = cs; c.cancel_tag = ct;
        return c;
    endfunction

    function automatic logic [62:0] rand_time();
        return 63'({$urandom(), $urandom()});
    endfunction

    // result checker: compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_result_strobe) begin
            if (expected_results.size() == 0) begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected result %p", o_result);
            end else begin
                automatic t_result e = expected_results.pop_front();
                if (o_result !== e) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", e, o_result);
                end
            end
        end
    end

    // extremes of every field, every mode, full table, bad cancels, saturation
    task automatic test_directed();
        begin
            send_command(make_cmd(MODE_TICK, '0, '0, '0, '0));        // tick on empty table
            send_command(make_cmd(MODE_CANCEL, '0, '0, 4'hf, 16'hffff)); // cancel on empty
            send_command(make_cmd(MODE_INSERT, 63'd100, 48'hffff_ffff_ffff, '0, '0));
            send_command(make_cmd(MODE_INSERT, 63'd100, '0, '0, '0)); // tie with same deadline
            send_command(make_cmd(MODE_INSERT, 63'd50, 48'd10, '0, '0));
            send_command(make_cmd(MODE_INSERT, TIME_MAX, 48'd1, '0, '0));
            send_command(make_cmd(MODE_CANCEL, '0, '0, 4'd1, 16'd3)); // wrong tag
            send_command(make_cmd(MODE_TICK, 63'd49, '0, '0, '0));   // nothing due
            send_command(make_cmd(MODE_TICK, 63'd100, '0, '0, '0));  // ordered expiry
            send_command(make_cmd(MODE_SPARE, TIME_MAX, '0, '0, '0)); // saturating re-arm
            for (int i = 0; i < SLOTS + 1; i++)                      // fill past full
                send_command(make_cmd(MODE_INSERT, 63'd7, '0, '0, '0));
            send_command(make_cmd(MODE_CANCEL, '0, '0, 4'd2, tmr_tag[2]));
            send_command(make_cmd(MODE_TICK, TIME_MAX, '0, '0, '0));  // many due at once
            send_command(make_cmd(MODE_TICK, TIME_MAX, '0, '0, '0));
        end
    endtask

    // hold off until every expected result has arrived
    task automatic drain_results();
        begin
            while (expected_results.size() != 0 || o_busy) @(posedge i_clk);
        end
    endtask

    // random mix weighted toward inserts and ticks that actually fire timers
    task automatic test_random(input int count);
        t_cmd c;
        int   sel;
        logic [62:0] now;
        begin
            now = 63'($urandom_range(1000));
            for (int n = 0; n < count; n++) begin
                if (n == count / 3) no_idle = 1'b1;
                if (n == count / 2) begin
                    no_idle = 1'b0;
                    drain_results();
                end
                sel = $urandom_range(99);
                c = make_cmd(2'(sel % 4), rand_time(), 48'({$urandom(), $urandom()}),
                             4'($urandom()), 16'($urandom()));
                if (sel < 40) begin
                    c.mode = MODE_INSERT;
                    if (sel < 36) c.time_value = now + 63'($urandom_range(200));
                    if (sel < 25) c.interval_us = (sel < 12) ? 48'd0 : 48'($urandom_range(150));
                end else if (sel < 60) begin
                    c.mode = MODE_CANCEL;
                    if (sel < 50) begin
                        c.cancel_slot = 4'($urandom_range(SLOTS - 1));
                        c.cancel_tag  = tmr_tag[c.cancel_slot];
                        if (!tmr_active[c.cancel_slot]) c.cancel_tag = last_tag;
                    end
                end else begin
                    c.mode = (sel < 97) ? MODE_TICK : MODE_SPARE;
                    if (sel < 95) begin
                        now = now + 63'($urandom_range(120));
                        c.time_value = now;
                    end
                end
                send_command(c);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd   = '0;
        no_idle = 1'b0;
        mismatch_count = 0;
        unexpected_count = 0;
        cycle_count = 0;
        tag_count = '0;
        order_count = '0;
        last_tag = '0;
        for (int i = 0; i < SLOTS; i++) begin
            tmr_active[i] = 1'b0; tmr_deadline[i] = '0; tmr_interval[i] = '0;
            tmr_tag[i] = '0; tmr_order[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(380);
        drain_results();
        repeat (400) @(posedge i_clk);
        if (mismatch_count == 0 && unexpected_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule
